>>> rtl/spf_pkg.sv
// spf_pkg: shared types and constants of the spectrum peak finder.
// Used by spectrum_peak_finder; no dependencies.
package spf_pkg;

  localparam int CMD_W   = 2;
  localparam int BIN_W   = 12;
  localparam int AMP_W   = 32;
  localparam int HZ_W    = 18;
  localparam int RATE_W  = 18;
  localparam int TS_W    = 13;
  localparam int FREQ_W  = 21;
  localparam int BAND_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_NEW   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEAK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_BANDS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSFORM   = 2'd1;

  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 18'd48000;
  localparam logic [TS_W-1:0]   TRANSFORM_RST   = 13'd2048;

  localparam logic [FREQ_W-1:0] FREQ_MAX = 21'h1FFFFF;

endpackage

>>> rtl/spf_div.sv
// spf_div: restoring serial divider, one quotient bit per cycle.
// Uses no package items; instantiated by spectrum_peak_finder.
module spf_div #(
  parameter int DW = 34,
  parameter int VW = 18
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] dvs_q, dvs_d;
  logic [VW:0]   sh;
  logic          ge;

  assign sh = {rem_q, quo_q[DW-1]};
  assign ge = sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? VW'(sh - {1'b0, dvs_q}) : VW'(sh);
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/spectrum_peak_finder.sv
// spectrum_peak_finder: top level, amplitude memory, query sequencer and caches.
// Depends on spf_pkg and spf_div.
//
// Bin writes are taken one per cycle between queries, straight into a
// single-port amplitude memory (MAX_TRANSFORM/2+1 words, registered read). A
// query that misses the cache maps both Hz limits through the shared serial
// divider, a band query then works out the chunk size, and the memory is read
// one bin per cycle over the range, chunk by chunk. Each result then needs one
// multiply and one more division (none, with frequency zero, when the transform
// size is zero) before it is offered. A cached query costs only that last step
// per result, and a query before a spectrum is loaded answers with an error
// status. The input is taken only between queries; the next word is accepted
// while the last result still waits in the output register. No clearing pass.
module spectrum_peak_finder #(
  parameter int MAX_TRANSFORM = 4096,
  parameter int BAND_COUNT    = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [spf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [spf_pkg::RATE_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [spf_pkg::CMD_W-1:0]     cmd_i,
  input  logic [spf_pkg::BIN_W-1:0]     bin_i,
  input  logic [spf_pkg::AMP_W-1:0]     amplitude_i,
  input  logic                          final_bin_i,
  input  logic [spf_pkg::HZ_W-1:0]      from_hz_i,
  input  logic [spf_pkg::HZ_W-1:0]      to_hz_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_o,
  output logic [spf_pkg::BAND_W-1:0]    band_o,
  output logic [spf_pkg::FREQ_W-1:0]    frequency_x16_o,
  output logic [spf_pkg::AMP_W-1:0]     peak_amplitude_o,
  output logic                          last_o
);

  localparam int DEPTH = MAX_TRANSFORM / 2 + 1;
  localparam int IDXW  = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int SW    = CNTW + 4;
  localparam int CHW   = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int PW    = IDXW + spf_pkg::RATE_W;
  localparam int DIVW  = (PW + 4 > 31) ? PW + 4 : 31;
  localparam int AW    = spf_pkg::AMP_W;
  localparam int RCP_SH = CNTW + 4;
  localparam int RCPW   = RCP_SH + 1;
  localparam longint RCP = ((64'd1 << RCP_SH) + BAND_COUNT - 1) / BAND_COUNT;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIV_LO = 4'd1;
  localparam logic [3:0] ST_DIV_HI = 4'd2;
  localparam logic [3:0] ST_DIV_N  = 4'd3;
  localparam logic [3:0] ST_CHUNK  = 4'd4;
  localparam logic [3:0] ST_SCAN   = 4'd5;
  localparam logic [3:0] ST_ADV    = 4'd6;
  localparam logic [3:0] ST_FMUL   = 4'd7;
  localparam logic [3:0] ST_FDIV   = 4'd8;
  localparam logic [3:0] ST_EMIT   = 4'd9;

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rdata_q;
  logic          rd_en;
  logic [IDXW-1:0] rd_addr;
  logic          wr_en;

  logic [3:0] state_q, state_d;
  logic [spf_pkg::RATE_W-1:0] rate_q, rate_d;
  logic [spf_pkg::TS_W-1:0]   ts_q, ts_d;
  logic [spf_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic [spf_pkg::HZ_W-1:0]   from_q, from_d, to_q, to_d;
  logic loaded_q, loaded_d, err_q, err_d;
  logic [CNTW-1:0] count_q, count_d;
  logic peak_cached_q, peak_cached_d, bands_cached_q, bands_cached_d;
  logic [IDXW-1:0] peak_bin_q, peak_bin_d;
  logic [AW-1:0]   peak_amp_q, peak_amp_d;
  logic [IDXW-1:0] band_bin_q [BAND_COUNT];
  logic [IDXW-1:0] band_bin_d [BAND_COUNT];
  logic [AW-1:0]   band_amp_q [BAND_COUNT];
  logic [AW-1:0]   band_amp_d [BAND_COUNT];
  logic [IDXW-1:0] start_q, start_d, end_q, end_d;
  logic [CNTW-1:0] size_q, size_d;
  logic [SW-1:0]   cs_q, cs_d;
  logic [CHW-1:0]  chunk_q, chunk_d;
  logic [CNTW-1:0] ptr_q, ptr_d, hi_q, hi_d;
  logic            pend_q, pend_d, first_q, first_d;
  logic [IDXW-1:0] pidx_q, pidx_d, best_bin_q, best_bin_d;
  logic [AW-1:0]   best_amp_q, best_amp_d;
  logic [PW-1:0]   prod_q, prod_d;
  logic [spf_pkg::FREQ_W-1:0] freq_q, freq_d;
  logic            go_q, go_d;

  logic out_valid_q, out_valid_d, status_q, status_d, last_q, last_d;
  logic [spf_pkg::BAND_W-1:0] band_q, band_d;
  logic [spf_pkg::FREQ_W-1:0] ofreq_q, ofreq_d;
  logic [AW-1:0] oamp_q, oamp_d;

  logic [DIVW-1:0] div_a, div_q;
  logic [spf_pkg::RATE_W-1:0] div_b;
  logic div_done;

  logic in_acc, is_peak, last_chunk, out_free, bin_ok;
  logic [IDXW-1:0] top, clamp;
  logic [SW-1:0]   endp1, ce_full, ce;
  logic [IDXW-1:0] cur_bin;
  logic [DIVW+3:0] fwide;
  logic [CNTW-1:0] span_n, span_q;
  logic [CNTW+RCPW-1:0] span_prod;

  spf_div #(.DW(DIVW), .VW(spf_pkg::RATE_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign in_ready_o  = state_q == ST_IDLE;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign is_peak     = cmd_q == spf_pkg::CMD_PEAK;
  assign last_chunk  = chunk_q == CHW'(BAND_COUNT - 1);
  assign out_free    = !out_valid_q || out_ready_i;
  assign bin_ok      = 32'(bin_i) < 32'(DEPTH);
  assign wr_en       = in_acc && cmd_i == spf_pkg::CMD_WRITE && bin_ok;

  assign top   = IDXW'(count_q - CNTW'(1));
  assign clamp = (div_q > DIVW'(top)) ? top : IDXW'(div_q);
  assign endp1   = SW'(end_q) + SW'(1);
  assign ce_full = cs_q + SW'(size_q);
  assign ce      = (ce_full > endp1) ? endp1 : ce_full;
  assign cur_bin = is_peak ? peak_bin_q : band_bin_q[chunk_q];
  assign fwide   = is_peak ? (DIVW+4)'(div_q) : {div_q, 4'b0000};

  // chunk size by reciprocal multiply, exact over the bin count range
  assign span_n    = CNTW'(end_q - start_q) + CNTW'(1);
  assign span_prod = (CNTW+RCPW)'(span_n) * (CNTW+RCPW)'(RCP);
  assign span_q    = span_prod[RCP_SH +: CNTW];

  always_comb begin
    div_a = '0;
    div_b = spf_pkg::RATE_W'(ts_q);
    case (state_q)
      ST_DIV_LO: begin
        div_a = DIVW'(from_q * ts_q);
        div_b = (rate_q == '0) ? spf_pkg::RATE_W'(1) : rate_q;
      end
      ST_DIV_HI: begin
        div_a = DIVW'(to_q * ts_q);
        div_b = (rate_q == '0) ? spf_pkg::RATE_W'(1) : rate_q;
      end
      ST_FDIV: begin
        div_a = is_peak ? DIVW'({prod_q, 4'b0000}) : DIVW'(prod_q);
      end
      default: ;
    endcase
  end

  assign rd_en   = state_q == ST_SCAN && ptr_q < hi_q;
  assign rd_addr = ptr_q[IDXW-1:0];

  always_comb begin
    state_d = state_q;
    rate_d = rate_q;
    ts_d = ts_q;
    cmd_d = cmd_q;
    from_d = from_q;
    to_d = to_q;
    loaded_d = loaded_q;
    err_d = err_q;
    count_d = count_q;
    peak_cached_d = peak_cached_q;
    bands_cached_d = bands_cached_q;
    peak_bin_d = peak_bin_q;
    peak_amp_d = peak_amp_q;
    band_bin_d = band_bin_q;
    band_amp_d = band_amp_q;
    start_d = start_q;
    end_d = end_q;
    size_d = size_q;
    cs_d = cs_q;
    chunk_d = chunk_q;
    ptr_d = ptr_q;
    hi_d = hi_q;
    pend_d = 1'b0;
    first_d = first_q;
    pidx_d = pidx_q;
    best_bin_d = best_bin_q;
    best_amp_d = best_amp_q;
    prod_d = prod_q;
    freq_d = freq_q;
    go_d = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d = status_q;
    band_d = band_q;
    ofreq_d = ofreq_q;
    oamp_d = oamp_q;
    last_d = last_q;

    if (cfg_valid_i) begin
      if (cfg_index_i == spf_pkg::CFG_SAMPLE_RATE) rate_d = cfg_data_i;
      else if (cfg_index_i == spf_pkg::CFG_TRANSFORM) ts_d = spf_pkg::TS_W'(cfg_data_i);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d = cmd_i;
          from_d = from_hz_i;
          to_d = to_hz_i;
          err_d = 1'b0;
          chunk_d = '0;
          case (cmd_i)
            spf_pkg::CMD_NEW: begin
              loaded_d = 1'b0;
              count_d = '0;
              peak_cached_d = 1'b0;
              bands_cached_d = 1'b0;
            end
            spf_pkg::CMD_WRITE: begin
              if (bin_ok && final_bin_i) begin
                loaded_d = 1'b1;
                count_d = CNTW'(32'(bin_i) + 32'd1);
              end
            end
            default: begin
              if (!loaded_q) begin
                err_d = 1'b1;
                state_d = ST_EMIT;
              end else if ((cmd_i == spf_pkg::CMD_PEAK && peak_cached_q) ||
                           (cmd_i == spf_pkg::CMD_BANDS && bands_cached_q)) begin
                state_d = ST_FMUL;
              end else begin
                state_d = ST_DIV_LO;
                go_d = 1'b1;
              end
            end
          endcase
        end
      end
      ST_DIV_LO: begin
        if (div_done) begin
          start_d = clamp;
          state_d = ST_DIV_HI;
          go_d = 1'b1;
        end
      end
      ST_DIV_HI: begin
        if (div_done) begin
          end_d = (clamp < start_q) ? start_q : clamp;
          if (is_peak) begin
            ptr_d = CNTW'(start_q);
            hi_d = CNTW'((clamp < start_q) ? start_q : clamp) + CNTW'(1);
            first_d = 1'b1;
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DIV_N;
          end
        end
      end
      ST_DIV_N: begin
        size_d = (span_q == '0) ? CNTW'(1) : span_q;
        cs_d = SW'(start_q);
        chunk_d = '0;
        state_d = ST_CHUNK;
      end
      ST_CHUNK: begin
        if (cs_q >= endp1) begin
          band_bin_d[chunk_q] = '0;
          band_amp_d[chunk_q] = '0;
          state_d = ST_ADV;
        end else begin
          ptr_d = cs_q[CNTW-1:0];
          hi_d = ce[CNTW-1:0];
          first_d = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          ptr_d = ptr_q + CNTW'(1);
          pend_d = 1'b1;
          pidx_d = ptr_q[IDXW-1:0];
        end
        if (pend_q) begin
          first_d = 1'b0;
          if (first_q || rdata_q > best_amp_q) begin
            best_bin_d = pidx_q;
            best_amp_d = rdata_q;
          end
        end
        if (!rd_en && !pend_q) begin
          if (is_peak) begin
            peak_bin_d = best_bin_q;
            peak_amp_d = best_amp_q;
            peak_cached_d = 1'b1;
            chunk_d = '0;
            state_d = ST_FMUL;
          end else begin
            band_bin_d[chunk_q] = best_bin_q;
            band_amp_d[chunk_q] = best_amp_q;
            state_d = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        cs_d = cs_q + SW'(size_q);
        if (last_chunk) begin
          bands_cached_d = 1'b1;
          chunk_d = '0;
          state_d = ST_FMUL;
        end else begin
          chunk_d = chunk_q + CHW'(1);
          state_d = ST_CHUNK;
        end
      end
      ST_FMUL: begin
        prod_d = PW'(cur_bin * rate_q);
        if (ts_q == '0) begin
          freq_d = '0;
          state_d = ST_EMIT;
        end else begin
          go_d = 1'b1;
          state_d = ST_FDIV;
        end
      end
      ST_FDIV: begin
        if (div_done) begin
          freq_d = (fwide > (DIVW+4)'(spf_pkg::FREQ_MAX)) ? spf_pkg::FREQ_MAX
                                                          : spf_pkg::FREQ_W'(fwide);
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d = err_q;
          band_d = (err_q || is_peak) ? '0 : spf_pkg::BAND_W'(chunk_q);
          ofreq_d = err_q ? '0 : freq_q;
          oamp_d = err_q ? '0 : (is_peak ? peak_amp_q : band_amp_q[chunk_q]);
          last_d = err_q || is_peak || last_chunk;
          if (err_q || is_peak || last_chunk) begin
            state_d = ST_IDLE;
          end else begin
            chunk_d = chunk_q + CHW'(1);
            state_d = ST_FMUL;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[IDXW'(bin_i)] <= amplitude_i;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rate_q <= spf_pkg::SAMPLE_RATE_RST;
      ts_q <= spf_pkg::TRANSFORM_RST;
      loaded_q <= 1'b0;
      count_q <= '0;
      peak_cached_q <= 1'b0;
      bands_cached_q <= 1'b0;
      peak_bin_q <= '0;
      peak_amp_q <= '0;
      for (int i = 0; i < BAND_COUNT; i++) begin
        band_bin_q[i] <= '0;
        band_amp_q[i] <= '0;
      end
      chunk_q <= '0;
      pend_q <= 1'b0;
      go_q <= 1'b0;
      err_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rate_q <= rate_d;
      ts_q <= ts_d;
      loaded_q <= loaded_d;
      count_q <= count_d;
      peak_cached_q <= peak_cached_d;
      bands_cached_q <= bands_cached_d;
      peak_bin_q <= peak_bin_d;
      peak_amp_q <= peak_amp_d;
      band_bin_q <= band_bin_d;
      band_amp_q <= band_amp_d;
      chunk_q <= chunk_d;
      pend_q <= pend_d;
      go_q <= go_d;
      err_q <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    from_q <= from_d;
    to_q <= to_d;
    start_q <= start_d;
    end_q <= end_d;
    size_q <= size_d;
    cs_q <= cs_d;
    ptr_q <= ptr_d;
    hi_q <= hi_d;
    first_q <= first_d;
    pidx_q <= pidx_d;
    best_bin_q <= best_bin_d;
    best_amp_q <= best_amp_d;
    prod_q <= prod_d;
    freq_q <= freq_d;
    status_q <= status_d;
    band_q <= band_d;
    ofreq_q <= ofreq_d;
    oamp_q <= oamp_d;
    last_q <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign band_o           = band_q;
  assign frequency_x16_o  = ofreq_q;
  assign peak_amplitude_o = oamp_q;
  assign last_o           = last_q;

endmodule
